// File: rtl/bffa_pkg.sv
// Package: shared types and constants for the bitmap first-free allocator.
`default_nettype none
package bffa_pkg;

  localparam int FIELD_W      = 14;
  localparam int FIELD_MAX    = 16383;
  localparam int MAP_BITS_DEF = 8192;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = 5;

  localparam logic [FIELD_W-1:0] MAP_SIZE_RESET = 14'd8192;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] entry_number;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_number;
    logic [FIELD_W-1:0] free_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_REL
  } state_t;

endpackage
`default_nettype wire

// File: rtl/bitmap_first_free_allocator_top.sv
// Bitmap first-free allocator: used-map in word memory, scanned by one word sequencer.
// Allocate: words are scanned from word 0 up to the word holding the first free entry or the
//   last word in range (word index at most ceil(map_size/32) - 1, 255 at default size).
// Release reads the entry's word first. Out-of-range release, or allocate with size zero,
//   is answered from idle. One request at a time (busy high while working); the scan reads
//   one 32-bit word per cycle from the memory's read port. The result strobe cannot be stalled.
// Reset (rst, synchronous): a clearing pass writes every map word, with busy high;
//   configuration writes are taken during it.
`default_nettype none
module bitmap_first_free_allocator_top
  import bffa_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               start,
  output logic                     busy,
  input  wire  in_t                cmd,
  output logic                     done,
  output out_t                     result,
  input  wire  logic               cfg_we,
  input  wire  logic [FIELD_W-1:0] cfg_wdata
);

  localparam int WORDS_MIN = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (WORDS_MIN > 1) ? $clog2(WORDS_MIN) : 1;
  localparam int DEPTH     = 2 ** AW;
  localparam int LIM       = (MAP_BITS > FIELD_MAX) ? FIELD_MAX : MAP_BITS;

  state_t             state, state_next;
  logic [AW-1:0]      addr, addr_next;
  logic [AW-1:0]      chk_addr, chk_addr_next;
  logic [FIELD_W-1:0] rel_num, rel_num_next;
  logic [FIELD_W-1:0] free_counter, free_counter_next;
  logic [FIELD_W-1:0] res_num, res_num_next;
  logic [FIELD_W-1:0] map_size;
  logic               done_next;

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  rdata;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  logic [FIELD_W-1:0] size, cfg_size, size_m1, num_m1, rel_m1, hit_idx;
  logic [AW-1:0]      last_addr;
  logic [BIT_W:0]     tail_n;
  logic [WORD_W-1:0]  tail_mask, free_bits;
  logic [BIT_W-1:0]   pe;
  logic               found, in_range;

  // effective size: map_size capped at the map
  assign size     = (map_size > FIELD_W'(LIM)) ? FIELD_W'(LIM) : map_size;
  assign cfg_size = (cfg_wdata > FIELD_W'(LIM)) ? FIELD_W'(LIM) : cfg_wdata;
  assign size_m1  = size - FIELD_W'(1);
  assign last_addr = AW'(size_m1 >> BIT_W);
  assign num_m1   = cmd.entry_number - FIELD_W'(1);
  assign rel_m1   = rel_num - FIELD_W'(1);
  assign in_range = (cmd.entry_number != '0) && (cmd.entry_number <= size);

  // last word may be only partly in range
  assign tail_n    = (size[BIT_W-1:0] == '0) ? (BIT_W+1)'(WORD_W)
                                              : {1'b0, size[BIT_W-1:0]};
  assign tail_mask = ~({WORD_W{1'b1}} << tail_n);
  assign free_bits = ~rdata & ((chk_addr == last_addr) ? tail_mask : {WORD_W{1'b1}});
  assign found     = |free_bits;

  always_comb begin
    pe = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) pe = BIT_W'(b);
    end
  end

  assign hit_idx = FIELD_W'({chk_addr, pe}) + FIELD_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next        = state;
    addr_next         = addr;
    chk_addr_next     = chk_addr;
    rel_num_next      = rel_num;
    free_counter_next = free_counter;
    res_num_next      = res_num;
    done_next         = 1'b0;
    mem_re            = 1'b0;
    mem_we            = 1'b0;
    mem_raddr         = addr;
    mem_waddr         = chk_addr;
    mem_wdata         = rdata;

    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
        mem_wdata = '0;
        addr_next = addr + AW'(1);
        if (addr == AW'(DEPTH - 1)) begin
          addr_next  = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd.func == FUNC_ALLOC) begin
            if (size == '0) begin
              done_next    = 1'b1;
              res_num_next = '0;
            end else begin
              mem_re        = 1'b1;
              mem_raddr     = '0;
              chk_addr_next = '0;
              addr_next     = AW'(1);
              state_next    = ST_SCAN;
            end
          end else begin
            if (in_range) begin
              mem_re       = 1'b1;
              mem_raddr    = AW'(num_m1 >> BIT_W);
              rel_num_next = cmd.entry_number;
              state_next   = ST_REL;
            end else begin
              done_next    = 1'b1;
              res_num_next = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        // read next word while checking the one that just came back
        mem_re        = 1'b1;
        mem_raddr     = addr;
        addr_next     = addr + AW'(1);
        chk_addr_next = addr;
        if (found) begin
          mem_we       = 1'b1;
          mem_waddr    = chk_addr;
          mem_wdata    = rdata | (WORD_W'(1) << pe);
          res_num_next = hit_idx;
          if (free_counter != '0) free_counter_next = free_counter - FIELD_W'(1);
          done_next    = 1'b1;
          addr_next    = '0;
          state_next   = ST_IDLE;
        end else if (chk_addr == last_addr) begin
          res_num_next = '0;
          done_next    = 1'b1;
          addr_next    = '0;
          state_next   = ST_IDLE;
        end
      end
      ST_REL: begin
        if (rdata[rel_m1[BIT_W-1:0]]) begin
          mem_we       = 1'b1;
          mem_waddr    = AW'(rel_m1 >> BIT_W);
          mem_wdata    = rdata & ~(WORD_W'(1) << rel_m1[BIT_W-1:0]);
          res_num_next = rel_num;
          if (free_counter != FIELD_W'(FIELD_MAX)) free_counter_next = free_counter + FIELD_W'(1);
        end else begin
          res_num_next = '0;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_we) free_counter_next = cfg_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      addr         <= '0;
      done         <= 1'b0;
      map_size     <= MAP_SIZE_RESET;
      free_counter <= (MAP_SIZE_RESET > FIELD_W'(LIM)) ? FIELD_W'(LIM) : MAP_SIZE_RESET;
    end else begin
      state        <= state_next;
      addr         <= addr_next;
      done         <= done_next;
      free_counter <= free_counter_next;
      if (cfg_we) map_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    rel_num  <= rel_num_next;
    res_num  <= res_num_next;
  end

  assign busy                 = (state != ST_IDLE);
  assign result.result_number = res_num;
  assign result.free_count    = free_counter;

endmodule
`default_nettype wire

// File: rtl/bffa_checker.sv
// Checker: port-level assertions for the allocator, bound to the top level.
`default_nettype none
module bffa_checker
  import bffa_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire in_t  cmd,
  input wire logic done,
  input wire out_t result
);

  // an accepted word either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted request neither answered nor busy");

  // result strobe only once the work is finished
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result strobe while busy");

  // release of entry zero fails at once
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.func == FUNC_RELEASE) && (cmd.entry_number == '0)
    |=> done && (result.result_number == '0))
    else $error("release of entry zero did not fail immediately");

endmodule

bind bitmap_first_free_allocator_top bffa_checker u_bffa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
`default_nettype wire

// File: tb/bitmap_first_free_allocator_top_tb.sv
// Testbench for the bitmap first-free allocator: queued requests checked against a predicted map.
`timescale 1ns / 100ps
module bitmap_first_free_allocator_top_tb;
  import bffa_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t cmd = '0;
  logic done;
  out_t result;
  logic cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  // predicted allocator state
  bit used_map [MAP_BITS_DEF];
  logic [FIELD_W-1:0] map_size_q = MAP_SIZE_RESET;
  logic [FIELD_W-1:0] free_ctr = MAP_SIZE_RESET;

  in_t queued_requests[$];
  out_t awaited_answers[$];
  bit tight_phase = 1'b0;
  int unsigned gap_left = 0;

  int unsigned fail_count = 0;
  int unsigned n_alloc_ok = 0;
  int unsigned n_alloc_fail = 0;
  int unsigned n_rel_ok = 0;
  int unsigned n_rel_fail = 0;
  int unsigned size_writes = 0;
  int unsigned deepest_entry = 0;

  bitmap_first_free_allocator_top #(.MAP_BITS(MAP_BITS_DEF)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_size();
    return (map_size_q > MAP_BITS_DEF) ? MAP_BITS_DEF : map_size_q;
  endfunction

  function automatic out_t next_allocator_answer(input in_t req);
    int unsigned lim;
    int unsigned i;
    bit found;
    out_t ans;
    lim = eff_size();
    found = 1'b0;
    ans.result_number = '0;
    if (req.func == FUNC_ALLOC) begin
      for (i = 0; i < lim && !found; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          found = 1'b1;
          if (free_ctr != 0) free_ctr = free_ctr - 1'b1;
          ans.result_number = i[FIELD_W-1:0] + 1'b1;
          if (i + 1 > deepest_entry) deepest_entry = i + 1;
        end
      end
      if (found) n_alloc_ok++;
      else n_alloc_fail++;
    end else if (req.entry_number != 0 && req.entry_number <= lim &&
                 used_map[req.entry_number - 1'b1]) begin
      used_map[req.entry_number - 1'b1] = 1'b0;
      if (free_ctr != FIELD_MAX) free_ctr = free_ctr + 1'b1;
      ans.result_number = req.entry_number;
      n_rel_ok++;
    end else begin
      n_rel_fail++;
    end
    ans.free_count = free_ctr;
    return ans;
  endfunction

  // request driver: one word per accepted start, random gap before the next one outside tight phases
  always @(posedge clk) begin : drive
    bit taken;
    taken = start && (busy === 1'b0);
    if (taken) awaited_answers.push_back(next_allocator_answer(cmd));
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || taken) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_requests.size() != 0) begin
        cmd <= queued_requests.pop_front();
        start <= 1'b1;
        gap_left <= tight_phase ? 0 : $urandom_range(0, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    out_t want;
    bit bad_num;
    bit bad_free;
    if (!rst && done === 1'b1) begin
      if (awaited_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result word with none expected: num %0d free %0d",
                   $realtime, result.result_number, result.free_count);
      end else begin
        want = awaited_answers.pop_front();
        bad_num = result.result_number !== want.result_number;
        bad_free = result.free_count !== want.free_count;
        if (bad_num || bad_free) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch%s%s: num exp %0d got %0d, free exp %0d got %0d",
                     $realtime, bad_num ? " result_number" : "",
                     bad_free ? " free_count" : "", want.result_number,
                     result.result_number, want.free_count, result.free_count);
        end
      end
    end
  end

  task automatic push_req(input logic f, input int unsigned n);
    in_t r;
    r.func = f;
    r.entry_number = n[FIELD_W-1:0];
    queued_requests.push_back(r);
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || awaited_answers.size() != 0 || start ||
           busy !== 1'b0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // size write also reloads the free counter; map bits stay
  task automatic write_size(input int unsigned v);
    wait_idle();
    cfg_wdata <= v[FIELD_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    map_size_q = v[FIELD_W-1:0];
    free_ctr = FIELD_W'(eff_size());
    size_writes++;
  endtask

  initial begin
    int unsigned sz;
    int unsigned eff;
    int unsigned items;
    int unsigned alloc_pct;
    int unsigned tally;
    int unsigned sel;
    int unsigned n;
    int unsigned lim;
    tally = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // default size: first fit, double release, out-of-range numbers
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, FIELD_MAX);
    push_req(FUNC_RELEASE, 2);
    push_req(FUNC_RELEASE, 2);
    push_req(FUNC_RELEASE, 0);
    push_req(FUNC_RELEASE, MAP_BITS_DEF + 1);
    push_req(FUNC_RELEASE, FIELD_MAX);
    push_req(FUNC_RELEASE, MAP_BITS_DEF);
    push_req(FUNC_RELEASE, 1);
    push_req(FUNC_ALLOC, 0);
    // zero size: everything fails
    write_size(0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 1);
    // size one with entry 1 already taken: full map, counter drift
    write_size(1);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 1);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 2);
    // size above the map is clipped
    write_size(FIELD_MAX);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, MAP_BITS_DEF);
    push_req(FUNC_ALLOC, 0);
    write_size(40);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 40);
    push_req(FUNC_RELEASE, 41);
    tally = 6;

    for (int ph = 0; ph < 15; ph++) begin
      case (ph)
        0:  sz = 32;
        1:  sz = 1;
        2:  sz = 33;
        3:  sz = 0;
        4:  sz = MAP_BITS_DEF;
        5:  sz = 2;
        6:  sz = 64;
        7:  sz = FIELD_MAX;
        8:  sz = 31;
        13: sz = $urandom_range(MAP_BITS_DEF + 1, FIELD_MAX);
        14: sz = $urandom_range(1, MAP_BITS_DEF);
        default: sz = $urandom_range(3, 1000);
      endcase
      write_size(sz);
      eff = (sz > MAP_BITS_DEF) ? MAP_BITS_DEF : sz;
      tight_phase = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(2, 9) * 10;
      items = (sz == 0) ? 12 : $urandom_range(110, 160);
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          push_req(FUNC_ALLOC, $urandom_range(0, FIELD_MAX));
          tally++;
        end else begin
          sel = $urandom_range(0, 99);
          lim = (tally == 0) ? 1 : tally;
          if (eff != 0 && lim > eff) lim = eff;
          if (eff == 0 || sel < 10) n = $urandom_range(0, FIELD_MAX);
          else if (sel < 18) n = (eff < FIELD_MAX) ? $urandom_range(eff + 1, FIELD_MAX) : 0;
          else if (sel < 22) n = 0;
          else if (sel < 35) n = $urandom_range(1, eff);
          else begin
            n = $urandom_range(1, lim);
            if (tally != 0) tally--;
          end
          push_req(FUNC_RELEASE, n);
        end
      end
    end

    while (queued_requests.size() != 0 || awaited_answers.size() != 0 || start)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d allocates (%0d failed) and %0d releases (%0d failed)",
             n_alloc_ok + n_alloc_fail, n_alloc_fail, n_rel_ok + n_rel_fail, n_rel_fail);
    $display("over %0d size writes, deepest entry handed out %0d, %0d errors",
             size_writes, deepest_entry, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d words still awaited", awaited_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/bffa_pkg.sv
rtl/bitmap_first_free_allocator_top.sv
rtl/bffa_checker.sv
tb/bitmap_first_free_allocator_top_tb.sv
